>>> src/ubx_nav_pvt_frame_parser_unit_macros.svh
// Assertion macros shared by the UBX NAV-PVT parser RTL.
`ifndef UBX_NAV_PVT_FRAME_PARSER_UNIT_MACROS_SVH
`define UBX_NAV_PVT_FRAME_PARSER_UNIT_MACROS_SVH

// Check an implication or expression on every clock edge out of reset.
`define UBXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds out of reset.
`define UBXP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> src/ubxp_pkg.sv
// Types, constants and field tables of the UBX NAV-PVT parser.
package ubxp_pkg;

  localparam logic [7:0]  SyncFirst  = 8'hB5;
  localparam logic [7:0]  SyncSecond = 8'h62;
  localparam logic [7:0]  ClassNav   = 8'h01;
  localparam logic [7:0]  IdNavPvt   = 8'h07;
  localparam logic [15:0] PvtLen     = 16'd92;

  localparam int PvtWords  = 23;
  localparam int NumFields = 18;
  localparam int PosW      = 7;
  localparam int WordAddrW = 5;
  localparam int FieldIdW  = 5;
  localparam int ValueW    = 33;

  localparam logic [PosW-1:0]     PayLastPos = PosW'(PvtLen - 16'd1);
  localparam logic [FieldIdW-1:0] LastField  = FieldIdW'(NumFields - 1);

  typedef enum logic [3:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_CLASS,
    ST_ID,
    ST_LEN1,
    ST_LEN2,
    ST_PAY,
    ST_CKA,
    ST_CKB,
    ST_FETCH,
    ST_SEND
  } state_e;

  typedef enum logic [2:0] {
    KIND_U8,
    KIND_BIT0,
    KIND_U16,
    KIND_U32,
    KIND_I32
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic frame_clr;
    logic sum_clr;
    logic class_ld;
    logic id_ld;
    logic len_lo_ld;
    logic len_hi_ld;
    logic sum_add;
    logic pay_wr;
    logic fld_clr;
    logic fld_inc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic pvt_hdr;
    logic len_zero;
    logic pay_last;
    logic cka_ok;
    logic ckb_ok;
    logic fld_last;
  } sts_t;

  // Payload word (4 bytes) that holds a field.
  function automatic logic [WordAddrW-1:0] field_word(input logic [FieldIdW-1:0] k);
    logic [WordAddrW-1:0] w;
    case (k)
      5'd0:                  w = 5'd0;
      5'd1, 5'd2, 5'd3:      w = 5'd5;
      5'd4:                  w = 5'd6;
      5'd5:                  w = 5'd7;
      5'd6:                  w = 5'd8;
      5'd7:                  w = 5'd9;
      5'd8:                  w = 5'd10;
      5'd9:                  w = 5'd11;
      5'd10:                 w = 5'd12;
      5'd11:                 w = 5'd13;
      5'd12:                 w = 5'd14;
      5'd13:                 w = 5'd15;
      5'd14:                 w = 5'd16;
      5'd15:                 w = 5'd17;
      5'd16:                 w = 5'd18;
      5'd17:                 w = 5'd19;
      default:               w = 5'd0;
    endcase
    return w;
  endfunction

  // Byte lane of the field's first byte within its word.
  function automatic logic [1:0] field_lane(input logic [FieldIdW-1:0] k);
    logic [1:0] l;
    case (k)
      5'd2:    l = 2'd1;
      5'd3:    l = 2'd3;
      default: l = 2'd0;
    endcase
    return l;
  endfunction

  function automatic kind_e field_kind(input logic [FieldIdW-1:0] k);
    kind_e t;
    case (k)
      5'd1, 5'd3:                               t = KIND_U8;
      5'd2:                                     t = KIND_BIT0;
      5'd17:                                    t = KIND_U16;
      5'd4, 5'd5, 5'd6, 5'd7, 5'd10, 5'd11,
      5'd12, 5'd13, 5'd14:                      t = KIND_I32;
      default:                                  t = KIND_U32;
    endcase
    return t;
  endfunction

  // Extract one field from its little-endian payload word.
  function automatic logic [ValueW-1:0] field_decode(input logic [31:0]         word,
                                                     input logic [FieldIdW-1:0] k);
    logic [7:0]        b;
    logic [ValueW-1:0] v;
    b = word[8*field_lane(k) +: 8];
    case (field_kind(k))
      KIND_U8:   v = {25'd0, b};
      KIND_BIT0: v = {32'd0, b[0]};
      KIND_U16:  v = {17'd0, word[15:0]};
      KIND_I32:  v = {word[31], word};
      default:   v = {1'b0, word};
    endcase
    return v;
  endfunction

endpackage

>>> src/ubxp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ubxp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ubxp_datapath.sv
// Datapath: header registers, Fletcher sums, payload store and field decode.
module ubxp_datapath import ubxp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [FieldIdW-1:0] field_id_o,
  output logic [ValueW-1:0]   field_value_o
);

  logic [7:0]            class_q, class_d;
  logic [7:0]            id_q, id_d;
  logic [15:0]           len_q, len_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [7:0]            sum_a_q, sum_a_d;
  logic [7:0]            sum_b_q, sum_b_d;
  logic [FieldIdW-1:0]   fld_q, fld_d;
  logic [23:0]           shift_q;
  logic [15:0]           len_full;
  logic                  word_we;
  logic [31:0]           rdata;

  assign len_full = {rx_byte_i, len_q[7:0]};

  always_comb begin
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    pos_d   = pos_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (cmd_i.frame_clr) begin
      class_d = '0;
      id_d    = '0;
      len_d   = '0;
      pos_d   = '0;
      sum_a_d = '0;
      sum_b_d = '0;
    end else begin
      if (cmd_i.sum_clr) begin
        sum_a_d = '0;
        sum_b_d = '0;
      end
      if (cmd_i.sum_add) begin
        sum_a_d = sum_a_q + rx_byte_i;
        sum_b_d = sum_b_q + sum_a_d;
      end
      if (cmd_i.class_ld) class_d = rx_byte_i;
      if (cmd_i.id_ld) id_d = rx_byte_i;
      if (cmd_i.len_lo_ld) len_d = {8'd0, rx_byte_i};
      if (cmd_i.len_hi_ld) begin
        len_d = len_full;
        pos_d = '0;
      end
      if (cmd_i.pay_wr) pos_d = pos_q + PosW'(1);
    end
  end

  always_comb begin
    fld_d = fld_q;
    if (cmd_i.fld_clr) begin
      fld_d = '0;
    end else if (cmd_i.fld_inc) begin
      fld_d = fld_q + FieldIdW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      fld_q   <= '0;
    end else begin
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      fld_q   <= fld_d;
    end
  end

  // Collect three bytes, write the word with the fourth.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_wr) begin
      shift_q <= {rx_byte_i, shift_q[23:8]};
    end
  end

  assign word_we = cmd_i.pay_wr && (pos_q[1:0] == 2'd3);

  ubxp_ram #(
    .Width (32),
    .Depth (PvtWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (pos_q[PosW-1:2]),
    .wdata_i ({rx_byte_i, shift_q}),
    .raddr_i (field_word(fld_q)),
    .rdata_o (rdata)
  );

  assign sts_o.sync1_hit = (rx_byte_i == SyncFirst);
  assign sts_o.sync2_hit = (rx_byte_i == SyncSecond);
  assign sts_o.pvt_hdr   = (class_q == ClassNav) && (id_q == IdNavPvt) && (len_full == PvtLen);
  assign sts_o.len_zero  = (len_full == 16'd0);
  assign sts_o.pay_last  = (pos_q == PayLastPos);
  assign sts_o.cka_ok    = (rx_byte_i == sum_a_q);
  assign sts_o.ckb_ok    = (rx_byte_i == sum_b_q) && (len_q == PvtLen);
  assign sts_o.fld_last  = (fld_q == LastField);

  assign field_id_o    = fld_q;
  assign field_value_o = field_decode(rdata, fld_q);

endmodule

>>> src/ubxp_ctrl.sv
// Controller: frame parse state machine and record emission sequencing.
module ubxp_ctrl import ubxp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   in_fire;

  // Take bytes in every parse state; hold them off while fields go out.
  assign in_ready_o = state_q inside {ST_SYNC1, ST_SYNC2, ST_CLASS, ST_ID, ST_LEN1,
                                      ST_LEN2, ST_PAY, ST_CKA, ST_CKB};
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SYNC1: if (in_fire && sts_i.sync1_hit) state_d = ST_SYNC2;
      ST_SYNC2: if (in_fire) state_d = sts_i.sync2_hit ? ST_CLASS : ST_SYNC1;
      ST_CLASS: if (in_fire) state_d = ST_ID;
      ST_ID:    if (in_fire) state_d = ST_LEN1;
      ST_LEN1:  if (in_fire) state_d = ST_LEN2;
      ST_LEN2: begin
        if (in_fire) begin
          if (sts_i.pvt_hdr) state_d = ST_PAY;
          else if (sts_i.len_zero) state_d = ST_CKA;
          else state_d = ST_SYNC1;
        end
      end
      ST_PAY:   if (in_fire && sts_i.pay_last) state_d = ST_CKA;
      ST_CKA:   if (in_fire) state_d = sts_i.cka_ok ? ST_CKB : ST_SYNC1;
      ST_CKB:   if (in_fire) state_d = sts_i.ckb_ok ? ST_FETCH : ST_SYNC1;
      ST_FETCH: state_d = ST_SEND;
      ST_SEND: begin
        if (out_ready_i) state_d = sts_i.fld_last ? ST_SYNC1 : ST_FETCH;
      end
      default:  state_d = ST_SYNC1;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_SYNC1: ;
      ST_SYNC2: cmd_o.sum_clr = in_fire && sts_i.sync2_hit;
      ST_CLASS: begin
        cmd_o.class_ld = in_fire;
        cmd_o.sum_add  = in_fire;
      end
      ST_ID: begin
        cmd_o.id_ld   = in_fire;
        cmd_o.sum_add = in_fire;
      end
      ST_LEN1: begin
        cmd_o.len_lo_ld = in_fire;
        cmd_o.sum_add   = in_fire;
      end
      ST_LEN2: begin
        cmd_o.len_hi_ld = in_fire;
        cmd_o.sum_add   = in_fire;
        cmd_o.frame_clr = in_fire && !sts_i.pvt_hdr && !sts_i.len_zero;
      end
      ST_PAY: begin
        cmd_o.pay_wr  = in_fire;
        cmd_o.sum_add = in_fire;
      end
      ST_CKA: cmd_o.frame_clr = in_fire && !sts_i.cka_ok;
      ST_CKB: begin
        cmd_o.frame_clr = in_fire;
        cmd_o.fld_clr   = in_fire;
      end
      ST_FETCH: ;
      ST_SEND: begin
        out_valid_o   = 1'b1;
        cmd_o.fld_inc = out_ready_i;
      end
      default: begin
        cmd_o.frame_clr = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/ubx_nav_pvt_frame_parser_unit.sv
// Top level of the UBX NAV-PVT frame parser: byte stream in, decoded fields out.
// tready stays high while a frame is parsed. After the second checksum byte of a good
// NAV-PVT frame, 18 fields come out; each is first read from its payload word in the RAM
// (FETCH) and then handed over (SEND) once the sink takes it, bytes held off meanwhile.
// Reset (async, low) returns to sync search with sums, header and field counter cleared;
// the payload RAM is not cleared.
`include "ubx_nav_pvt_frame_parser_unit_macros.svh"

module ubx_nav_pvt_frame_parser_unit import ubxp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input request.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Decoded field output request.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [4:0] field_id, [37:5] field_value, [39:38] zero
  output logic        m_axis_tlast    // last_field
);

  cmd_t                cmd;
  sts_t                sts;
  logic [FieldIdW-1:0] field_id;
  logic [ValueW-1:0]   field_value;

  // Sequence the frame bytes and the field emission.
  ubxp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the header, sums and payload; decode the current field.
  ubxp_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .field_id_o    (field_id),
    .field_value_o (field_value)
  );

  assign m_axis_tdata = {2'b00, field_value, field_id};
  assign m_axis_tlast = sts.fld_last;

  // Byte intake and field emission never overlap.
  `UBXP_ASSERT_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid, "input open while emitting")
  // After the last field, go straight back to byte intake.
  `UBXP_ASSERT(a_last_returns, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid), "no return to intake after record")
  // Right after each field but the last, the RAM fetch state follows with both sides closed.
  `UBXP_ASSERT(a_fetch_gap, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (!s_axis_tready && !m_axis_tvalid), "missing fetch cycle between fields")

endmodule

>>> verif/testbench.sv
// Self-checking testbench of the UBX NAV-PVT frame parser, with byte stream and field scoreboard.
module testbench import ubxp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Abort when no request moves on either side for this many cycles.
  localparam int StallLimit   = 4000;
  // Cycles the field sink holds off once, mid-record, so the parser backs up.
  localparam int HoldCycles   = 400;
  // Cycles to keep watching after the last expected field has arrived.
  localparam int DrainCycles  = 60;
  localparam int TargetBytes  = 320;
  localparam int CalmBytes    = 240;
  localparam int PvtBytes     = 92;

  // Payload byte offset and decode kind of each NAV-PVT field, by field id.
  localparam int FieldOffset [NumFields] = '{
    0, 20, 21, 23, 24, 28, 32, 36, 40, 44, 48, 52, 56, 60, 64, 68, 72, 76
  };
  localparam kind_e FieldKind [NumFields] = '{
    KIND_U32, KIND_U8, KIND_BIT0, KIND_U8,
    KIND_I32, KIND_I32, KIND_I32, KIND_I32,
    KIND_U32, KIND_U32,
    KIND_I32, KIND_I32, KIND_I32, KIND_I32, KIND_I32,
    KIND_U32, KIND_U32, KIND_U16
  };

  // Checksum fault to inject into a frame.
  typedef enum int {
    CK_GOOD,
    CK_BAD_A,
    CK_BAD_B
  } ck_fault_e;

  typedef logic [7:0] byte_q_t[$];

  // One decoded field as it leaves the parser.
  typedef struct {
    logic [FieldIdW-1:0] id;
    logic [ValueW-1:0]   value;
    logic                last;
  } pvt_field_t;

  // Tracks the frame parse of every accepted byte and holds the fields it owes.
  class pvt_scoreboard;
    state_e     st;
    logic [7:0] cls;
    logic [7:0] mid;
    logic [15:0] len;
    logic [6:0] pos;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] pay [PvtBytes];
    pvt_field_t pending[$];
    int errors;
    int records;
    int fields_seen;

    function new();
      clear_frame();
      foreach (pay[i]) pay[i] = 8'h00;
      errors      = 0;
      records     = 0;
      fields_seen = 0;
    endfunction

    // Drop the frame and go back to sync search.
    function void clear_frame();
      st   = ST_SYNC1;
      cls  = 8'h00;
      mid  = 8'h00;
      len  = 16'h0000;
      pos  = '0;
      ck_a = 8'h00;
      ck_b = 8'h00;
    endfunction

    function void add_sum(input logic [7:0] b);
      ck_a = ck_a + b;
      ck_b = ck_b + ck_a;
    endfunction

    // Advance the parse by one accepted byte; queue a record on a good NAV-PVT frame.
    function void note_byte(input logic [7:0] b);
      pvt_field_t   f;
      int           o;
      logic [31:0]  w;
      case (st)
        ST_SYNC1: begin
          if (b == SyncFirst) st = ST_SYNC2;
        end
        ST_SYNC2: begin
          // A wrong second sync byte restarts the search, even when it is 0xB5.
          if (b == SyncSecond) begin
            ck_a = 8'h00;
            ck_b = 8'h00;
            st   = ST_CLASS;
          end else begin
            st = ST_SYNC1;
          end
        end
        ST_CLASS: begin
          cls = b;
          add_sum(b);
          st = ST_ID;
        end
        ST_ID: begin
          mid = b;
          add_sum(b);
          st = ST_LEN1;
        end
        ST_LEN1: begin
          len = {8'h00, b};
          add_sum(b);
          st = ST_LEN2;
        end
        ST_LEN2: begin
          len[15:8] = b;
          add_sum(b);
          pos = '0;
          if (cls == ClassNav && mid == IdNavPvt && len == PvtLen) begin
            st = ST_PAY;
          end else if (len == 16'h0000) begin
            st = ST_CKA;
          end else begin
            clear_frame();
          end
        end
        ST_PAY: begin
          pay[pos] = b;
          pos = pos + 7'd1;
          add_sum(b);
          if (pos >= PosW'(PvtBytes)) st = ST_CKA;
        end
        ST_CKA: begin
          if (b == ck_a) st = ST_CKB;
          else clear_frame();
        end
        ST_CKB: begin
          // Only a NAV-PVT frame yields fields; a good zero-length frame is ignored.
          if (b == ck_b && len == PvtLen) begin
            for (int k = 0; k < NumFields; k++) begin
              o = FieldOffset[k];
              w = {pay[o+3], pay[o+2], pay[o+1], pay[o]};
              f.id   = FieldIdW'(k);
              f.last = (k == NumFields - 1);
              case (FieldKind[k])
                KIND_U8:   f.value = {25'd0, pay[o]};
                KIND_BIT0: f.value = {32'd0, pay[o][0]};
                KIND_U16:  f.value = {17'd0, w[15:0]};
                KIND_I32:  f.value = {w[31], w};
                default:   f.value = {1'b0, w};
              endcase
              pending.push_back(f);
            end
            records++;
          end
          clear_frame();
        end
        default: clear_frame();
      endcase
    endfunction

    // Compare one accepted field request with the oldest owed field.
    function void check_result(input logic [FieldIdW-1:0] id, input logic [ValueW-1:0] value,
                               input logic last, input logic [1:0] pad);
      pvt_field_t f;
      fields_seen++;
      if (pending.size() == 0) begin
        $error("unexpected field result: field_id %0d field_value 'h%0h", id, value);
        errors++;
        return;
      end
      f = pending.pop_front();
      if (id !== f.id) begin
        $error("field_id mismatch: expected %0d, actual %0d", f.id, id);
        errors++;
      end
      if (value !== f.value) begin
        $error("field_value mismatch (field %0d): expected 'h%09h, actual 'h%09h",
               f.id, f.value, value);
        errors++;
      end
      if (last !== f.last) begin
        $error("last_field mismatch (field %0d): expected %0b, actual %0b", f.id, f.last, last);
        errors++;
      end
      if (pad !== 2'b00) begin
        $error("tdata pad mismatch (field %0d): expected 0, actual %0b", f.id, pad);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  pvt_scoreboard sb = new();

  // No idle bursts once set; the tail of the run streams at full rate.
  bit calm      = 1'b0;
  // Odds (1 in n) of an idle burst before a byte; zero turns bursts off.
  int gap_odds  = 4;
  int bytes_sent = 0;
  int quiet     = 0;

  ubx_nav_pvt_frame_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [4:0] field_id, [37:5] field_value, [39:38] zero
    .m_axis_tlast  (m_axis_tlast)    // last_field
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Offer one byte request, maybe after an idle burst, and hold it until taken.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Wrap a body into a UBX frame, with its checksum optionally broken.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] mid,
                            input logic [15:0] len, input byte_q_t body,
                            input ck_fault_e fault);
    byte_q_t    stream;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    stream = {cls, mid, len[7:0], len[15:8]};
    stream = {stream, body};
    ck_a = 8'h00;
    ck_b = 8'h00;
    foreach (stream[i]) begin
      ck_a = ck_a + stream[i];
      ck_b = ck_b + ck_a;
    end
    if (fault == CK_BAD_A) ck_a = ck_a ^ 8'($urandom_range(1, 255));
    if (fault == CK_BAD_B) ck_b = ck_b ^ 8'($urandom_range(1, 255));
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    foreach (stream[i]) send_byte(stream[i]);
    send_byte(ck_a);
    send_byte(ck_b);
  endtask

  // Build a payload; a harsh one uses only sign and boundary byte patterns.
  function automatic byte_q_t make_body(input int n, input bit harsh);
    byte_q_t q;
    for (int i = 0; i < n; i++) begin
      if (!harsh) begin
        q.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 4))
          0:       q.push_back(8'h00);
          1:       q.push_back(8'hFF);
          2:       q.push_back(8'h80);
          3:       q.push_back(8'h7F);
          default: q.push_back(8'h01);
        endcase
      end
    end
    return q;
  endfunction

  // Field sink: check each taken field request, then pick tready for the next cycle.
  initial begin : field_sink
    int  idle_left;
    int  hold_left;
    bit  held;
    idle_left = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata[4:0], m_axis_tdata[37:5], m_axis_tlast,
                        m_axis_tdata[39:38]);
      end
      // Hold off once in the middle of the first record so the parser backs up its input.
      if (!held && sb.fields_seen == 5) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(1, 10) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when neither side moves a request for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= StallLimit) begin
      $display("FAIL ubx_nav_pvt_frame_parser_unit");
      $finish;
    end
  end

  initial begin : byte_source
    byte_q_t    none;
    byte_q_t    body;
    int         pick;
    int         pvt_frames;
    logic [7:0] cls;
    logic [7:0] mid;
    logic [15:0] len;
    pvt_frames = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad second sync byte that is itself 0xB5, then a stray 0x62 to ignore.
    send_byte(SyncFirst);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    // Good zero-length frame with extreme class and id: checked, nothing comes out.
    send_frame(8'hFF, 8'h00, 16'h0000, none, CK_GOOD);
    // Zero-length frame with a bad first checksum byte: dropped.
    send_frame(ClassNav, IdNavPvt, 16'h0000, none, CK_BAD_A);
    // Other frame kind: dropped right after its length, the rest parses as noise.
    send_frame(8'h0A, 8'h04, 16'h0002, make_body(2, 1'b1), CK_GOOD);

    // Random: mostly NAV-PVT frames with random content, the rest broken frames and noise.
    while (bytes_sent < TargetBytes || sb.records < 3) begin
      if (bytes_sent >= CalmBytes) calm = 1'b1;
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
      // Force the first frame to be a good record so the hold-off lands mid-record.
      pick = (pvt_frames == 0) ? 0 : $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3, 4: begin
          send_frame(ClassNav, IdNavPvt, PvtLen,
                     make_body(PvtBytes, $urandom_range(0, 3) == 0), CK_GOOD);
          pvt_frames++;
        end
        5: send_frame(ClassNav, IdNavPvt, PvtLen, make_body(PvtBytes, 1'b0), CK_BAD_A);
        6: send_frame(ClassNav, IdNavPvt, PvtLen, make_body(PvtBytes, 1'b0), CK_BAD_B);
        7: begin
          cls = ($urandom_range(0, 1) == 0) ? ClassNav : 8'($urandom_range(0, 255));
          mid = ($urandom_range(0, 1) == 0) ? IdNavPvt : 8'($urandom_range(0, 255));
          send_frame(cls, mid, 16'h0000, none, ck_fault_e'($urandom_range(0, 2)));
        end
        8: begin
          // Near misses of the NAV-PVT header, or any other kind with a short body.
          case ($urandom_range(0, 3))
            0:       len = PvtLen - 16'd1;
            1:       len = PvtLen + 16'd1;
            2:       len = {8'($urandom_range(1, 255)), PvtLen[7:0]};
            default: len = 16'($urandom_range(1, 65535));
          endcase
          cls = ($urandom_range(0, 1) == 0) ? ClassNav : 8'($urandom_range(0, 255));
          mid = ($urandom_range(0, 1) == 0) ? IdNavPvt : 8'($urandom_range(0, 255));
          if (cls == ClassNav && mid == IdNavPvt && len == PvtLen) mid = IdNavPvt + 8'd1;
          body = make_body($urandom_range(0, 6), 1'b0);
          send_frame(cls, mid, len, body, CK_GOOD);
        end
        default: begin
          // Line noise, rich in first sync bytes.
          repeat ($urandom_range(1, 6)) begin
            send_byte(($urandom_range(0, 3) == 0) ? SyncFirst : 8'($urandom_range(0, 255)));
          end
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every owed field, then watch a while for strays.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d expected fields never arrived", sb.pending.size());
      sb.errors++;
    end

    $display("Sent %0d bytes in %0d NAV-PVT frames plus broken frames, zero-length frames, noise",
             bytes_sent, pvt_frames);
    $display("Checked %0d field results from %0d decoded records", sb.fields_seen, sb.records);
    if (sb.errors == 0) begin
      $display("PASS ubx_nav_pvt_frame_parser_unit");
    end else begin
      $display("FAIL ubx_nav_pvt_frame_parser_unit");
    end
    $finish;
  end

endmodule
